// ===== src/bdq_pkg.sv =====
package bdq_pkg;

    localparam int CMD_W = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_READ_AT    = 3'd3,
        CMD_KEEP_FIRST = 3'd4,
        CMD_DROP_FIRST = 3'd5,
        CMD_CLEAR      = 3'd6
    } t_cmd;

endpackage

// ===== src/bounded_array_deque_top.sv =====
// Channel    Direction  Contents (lowest bit first)
// -------    ---------  ------------------------------------------------
// s_axis     in         one request: cmd, value, position
// m_axis     out        one result per request: read_value, count,
//                       list_empty, error
//
// Every request completes on acceptance: front pointer and count live
// in flip-flops, and the storage ring is one RAM with one write and one
// registered read port, so a request can be taken on every clock.
// The result appears on the cycle after its request is accepted.
// A new request is taken whenever the result register is empty or is
// being taken in the same cycle; a stalled result holds it back.
// Reset clears the count, the front pointer and the result valid flag.
module bounded_array_deque_top #(
    parameter int DEPTH      = 128,
    parameter int DATA_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // cmd, value, position, zero padding
    input  logic [((bdq_pkg::CMD_W + DATA_WIDTH + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0]
                                 i_s_tdata,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // read_value, count, list_empty, error, zero padding
    output logic [((DATA_WIDTH + $clog2(DEPTH + 1) + 2 + 7) / 8) * 8 - 1:0]
                                 o_m_tdata
);
    import bdq_pkg::*;

    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int SW    = CW + 1;
    localparam int OUT_W = ((DATA_WIDTH + CW + 2 + 7) / 8) * 8;
    localparam int PAD_W = OUT_W - DATA_WIDTH - CW - 2;

    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
    localparam logic [SW-1:0] DEPTH_S    = SW'(DEPTH);
    localparam logic [PW-1:0] LAST_SLOT  = PW'(DEPTH - 1);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];

    logic                  r_m_tvalid;
    logic [PW-1:0]         r_front;
    logic [CW-1:0]         r_count;
    logic                  r_err;
    logic                  r_rd_en;
    logic [DATA_WIDTH-1:0] r_rd;

    logic [PW-1:0]         n_front;
    logic [CW-1:0]         n_count;
    logic                  s_err;
    logic                  s_rd_en;
    logic                  s_we;
    logic [PW-1:0]         s_waddr;
    logic [PW-1:0]         s_raddr;
    logic [PW-1:0]         s_front_dec;
    logic [PW-1:0]         s_back_slot;
    logic [PW-1:0]         s_next_slot;
    logic                  s_accept;

    t_cmd                  s_cmd;
    logic [DATA_WIDTH-1:0] s_value;
    logic [CW-1:0]         s_pos;

    // Ring slot at a given distance from the front; valid offsets stay
    // below twice the depth, so one conditional subtract wraps it.
    function automatic logic [PW-1:0] slot_of(input logic [PW-1:0] front,
                                              input logic [CW-1:0] offset);
        logic [SW-1:0] sum;
        sum = SW'(front) + SW'(offset);
        if (sum >= DEPTH_S) begin
            sum = sum - DEPTH_S;
        end
        return sum[PW-1:0];
    endfunction

    assign s_cmd   = t_cmd'(i_s_tdata[CMD_W-1:0]);
    assign s_value = i_s_tdata[CMD_W +: DATA_WIDTH];
    assign s_pos   = i_s_tdata[CMD_W + DATA_WIDTH +: CW];

    assign o_s_tready = !r_m_tvalid || i_m_tready;
    assign s_accept   = i_s_tvalid && o_s_tready;

    assign s_front_dec = (r_front == '0) ? LAST_SLOT : r_front - PW'(1);
    assign s_back_slot = slot_of(r_front, r_count);
    assign s_next_slot = slot_of(r_front, CW'(1));
    assign s_raddr     = slot_of(r_front, s_pos);

    always_comb begin
        n_front = r_front;
        n_count = r_count;
        s_err   = 1'b0;
        s_rd_en = 1'b0;
        s_we    = 1'b0;
        s_waddr = s_back_slot;
        case (s_cmd)
            CMD_PUSH_FRONT: begin
                if (r_count == FULL_COUNT) begin
                    s_err = 1'b1;
                end else begin
                    n_front = s_front_dec;
                    s_waddr = s_front_dec;
                    s_we    = 1'b1;
                    n_count = r_count + CW'(1);
                end
            end
            CMD_PUSH_BACK: begin
                if (r_count == FULL_COUNT) begin
                    s_err = 1'b1;
                end else begin
                    s_we    = 1'b1;
                    n_count = r_count + CW'(1);
                end
            end
            CMD_POP_FRONT: begin
                if (r_count == '0) begin
                    s_err = 1'b1;
                end else begin
                    n_front = s_next_slot;
                    n_count = r_count - CW'(1);
                end
            end
            CMD_READ_AT: begin
                if (s_pos >= r_count) begin
                    s_err = 1'b1;
                end else begin
                    s_rd_en = 1'b1;
                end
            end
            CMD_KEEP_FIRST: begin
                if (s_pos > r_count) begin
                    s_err = 1'b1;
                end else begin
                    n_count = s_pos;
                end
            end
            CMD_DROP_FIRST: begin
                if (s_pos >= r_count) begin
                    s_err = 1'b1;
                end else begin
                    n_front = s_raddr;
                    n_count = r_count - s_pos;
                end
            end
            CMD_CLEAR: begin
                n_front = '0;
                n_count = '0;
            end
            default: begin
                s_err = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
            r_front    <= '0;
            r_count    <= '0;
        end else begin
            if (o_s_tready) begin
                r_m_tvalid <= i_s_tvalid;
            end
            if (s_accept) begin
                r_front <= n_front;
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_err   <= s_err;
            r_rd_en <= s_rd_en;
        end
    end

    // Storage ring: one write port, one read port with registered data.
    always_ff @(posedge i_clk) begin
        if (s_accept && s_we) begin
            r_mem[s_waddr] <= s_value;
        end
        if (s_accept) begin
            r_rd <= r_mem[s_raddr];
        end
    end

    // The count register already holds the count after the last request.
    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = {{PAD_W{1'b0}}, r_err, (r_count == '0), r_count,
                         (r_rd_en ? r_rd : {DATA_WIDTH{1'b0}})};

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("element count exceeds the depth");

    a_front_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_front <= LAST_SLOT)
        else $error("front pointer outside the ring");

    a_err_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && s_err |=> r_count == $past(r_count) && r_front == $past(r_front))
        else $error("failed request changed the list");

    a_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && (s_cmd != CMD_READ_AT) |=> o_m_tdata[DATA_WIDTH-1:0] == '0)
        else $error("read value nonzero on a request that is not a read");

    a_error_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && s_rd_en |=> !r_err && r_m_tvalid)
        else $error("successful read reported as failed");

endmodule

// ===== verif/bounded_array_deque_top_test.sv =====
`timescale 1ns / 1ps

module bounded_array_deque_top_test;
    import bdq_pkg::*;

    localparam int DEPTH      = 128;
    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int IN_W       = ((CMD_W + DATA_WIDTH + CNT_W + 7) / 8) * 8;
    localparam int OUT_W      = ((DATA_WIDTH + CNT_W + 2 + 7) / 8) * 8;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

    // Packed with read_value in the lowest bits, as on the result bus.
    typedef struct packed {
        logic                  error;
        logic                  list_empty;
        logic [CNT_W-1:0]      count;
        logic [DATA_WIDTH-1:0] read_value;
    } t_result;

    class deque_scoreboard;
        logic [DATA_WIDTH-1:0] ring [DEPTH];
        logic [6:0]            head;
        int                    fill;
        t_result               pending[$];
        int                    failures;
        int                    requests;
        int                    refused;
        int                    peak_fill;

        function new();
            head      = '0;
            fill      = 0;
            failures  = 0;
            requests  = 0;
            refused   = 0;
            peak_fill = 0;
        endfunction

        function logic [6:0] slot(int offset);
            return 7'(head + offset);
        endfunction

        function void note_request(logic [CMD_W-1:0] op, logic [DATA_WIDTH-1:0] word,
                                   logic [CNT_W-1:0] pos);
            t_result r;
            r = '0;
            case (op)
                CMD_PUSH_FRONT: begin
                    if (fill >= DEPTH) begin
                        r.error = 1'b1;
                    end else begin
                        head       = head - 7'd1;
                        ring[head] = word;
                        fill++;
                    end
                end
                CMD_PUSH_BACK: begin
                    if (fill >= DEPTH) begin
                        r.error = 1'b1;
                    end else begin
                        ring[slot(fill)] = word;
                        fill++;
                    end
                end
                CMD_POP_FRONT: begin
                    if (fill == 0) begin
                        r.error = 1'b1;
                    end else begin
                        head = slot(1);
                        fill--;
                    end
                end
                CMD_READ_AT: begin
                    if (int'(pos) >= fill) r.error = 1'b1;
                    else r.read_value = ring[slot(int'(pos))];
                end
                CMD_KEEP_FIRST: begin
                    if (int'(pos) > fill) r.error = 1'b1;
                    else fill = int'(pos);
                end
                CMD_DROP_FIRST: begin
                    if (int'(pos) >= fill) begin
                        r.error = 1'b1;
                    end else begin
                        head = slot(int'(pos));
                        fill -= int'(pos);
                    end
                end
                CMD_CLEAR: begin
                    fill = 0;
                    head = '0;
                end
                default: r.error = 1'b1;
            endcase
            r.count      = CNT_W'(fill);
            r.list_empty = (fill == 0);
            requests++;
            if (r.error) refused++;
            if (fill > peak_fill) peak_fill = fill;
            pending.push_back(r);
        endfunction

        function void compare_field(string name, logic [DATA_WIDTH-1:0] want,
                                    logic [DATA_WIDTH-1:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
                failures++;
            end
        endfunction

        function void check_result(logic [OUT_W-1:0] bus);
            t_result got;
            t_result want;
            got = bus[$bits(t_result)-1:0];
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h, expected none", $time, got);
                failures++;
                return;
            end
            want = pending.pop_front();
            compare_field("read_value", want.read_value, got.read_value);
            compare_field("count", DATA_WIDTH'(want.count), DATA_WIDTH'(got.count));
            compare_field("list_empty", DATA_WIDTH'(want.list_empty),
                          DATA_WIDTH'(got.list_empty));
            compare_field("error", DATA_WIDTH'(want.error), DATA_WIDTH'(got.error));
        endfunction
    endclass

    logic              i_clk    = 1'b0;
    logic              rst_n    = 1'b0;
    logic              s_tvalid = 1'b0;
    logic [IN_W-1:0]   s_tdata  = '0;
    logic              m_tready = 1'b0;
    logic              o_s_tready;
    logic              o_m_tvalid;
    logic [OUT_W-1:0]  o_m_tdata;

    deque_scoreboard sb = new();
    int  send_idle_pct   = 31;
    int  recv_idle_pct   = 86;
    bit  hold_off_req    = 1'b0;
    int  stalled_cycles  = 0;

    bounded_array_deque_top #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (rst_n) begin
            if (o_m_tvalid && m_tready) sb.check_result(o_m_tdata);
            if (s_tvalid && !o_s_tready) stalled_cycles++;
        end
    end

    // Result side: random back-pressure, plus one long hold-off on request.
    initial begin
        wait (rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        #1_000_000;
        $display("Timeout with %0d results outstanding", sb.pending.size());
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic send_request(logic [CMD_W-1:0] op, logic [DATA_WIDTH-1:0] word,
                                logic [CNT_W-1:0] pos);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_W'({pos, word, op});
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_request(op, word, pos);
    endtask

    // Positions cluster around the current occupancy so that both the
    // in-range and the just-out-of-range cases come up often.
    function automatic logic [CNT_W-1:0] pick_position(int fill);
        int pick;
        pick = $urandom_range(9);
        if (pick <= 6) return CNT_W'($urandom_range(fill));
        if (pick == 7) return CNT_W'(fill);
        if (pick == 8) return CNT_W'((fill < 255) ? fill + 1 : 255);
        return CNT_W'($urandom_range(255));
    endfunction

    task automatic random_requests(int n);
        int               pick;
        logic [CMD_W-1:0] op;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(99);
            if (pick < 22)      op = CMD_PUSH_FRONT;
            else if (pick < 48) op = CMD_PUSH_BACK;
            else if (pick < 58) op = CMD_POP_FRONT;
            else if (pick < 78) op = CMD_READ_AT;
            else if (pick < 85) op = CMD_KEEP_FIRST;
            else if (pick < 95) op = CMD_DROP_FIRST;
            else if (pick < 98) op = CMD_CLEAR;
            else                op = CMD_UNUSED;
            send_request(op, $urandom, pick_position(sb.fill));
        end
    endtask

    initial begin
        int spins;
        repeat (3) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // Requests on an empty list, all but one refused, then the boundaries of a short list.
        send_request(CMD_READ_AT,    '0, 8'd0);
        send_request(CMD_POP_FRONT,  '0, 8'd0);
        send_request(CMD_DROP_FIRST, '0, 8'd0);
        send_request(CMD_KEEP_FIRST, '0, 8'd0);
        send_request(CMD_KEEP_FIRST, '0, 8'd1);
        send_request(CMD_UNUSED,     '1, 8'd255);
        send_request(CMD_PUSH_FRONT, 32'h0000_0000, 8'd0);
        send_request(CMD_PUSH_BACK,  32'hFFFF_FFFF, 8'd255);
        send_request(CMD_PUSH_FRONT, 32'h8000_0001, 8'd128);
        send_request(CMD_READ_AT,    '0, 8'd0);
        send_request(CMD_READ_AT,    '0, 8'd1);
        send_request(CMD_READ_AT,    '0, 8'd2);
        send_request(CMD_READ_AT,    '0, 8'd3);
        send_request(CMD_READ_AT,    '0, 8'd255);
        send_request(CMD_KEEP_FIRST, '0, 8'd4);
        send_request(CMD_KEEP_FIRST, '0, 8'd3);
        send_request(CMD_DROP_FIRST, '0, 8'd3);
        send_request(CMD_DROP_FIRST, '0, 8'd1);
        send_request(CMD_READ_AT,    '0, 8'd0);
        send_request(CMD_POP_FRONT,  '0, 8'd0);
        send_request(CMD_CLEAR,      '0, 8'd0);
        send_request(CMD_CLEAR,      '0, 8'd0);
        random_requests(170);

        send_idle_pct = 86;
        recv_idle_pct = 31;
        random_requests(170);

        // Sender runs flat out into a long result stall, then fills the list.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_req  = 1'b1;
        while (sb.fill < DEPTH) begin
            send_request($urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT,
                         $urandom, CNT_W'($urandom_range(255)));
        end
        send_request(CMD_PUSH_BACK,  $urandom, 8'd0);
        send_request(CMD_PUSH_FRONT, $urandom, 8'd0);
        send_request(CMD_READ_AT,    '0, 8'd127);
        send_request(CMD_READ_AT,    '0, 8'd128);
        send_request(CMD_READ_AT,    '0, 8'd0);
        send_request(CMD_KEEP_FIRST, '0, 8'd129);
        send_request(CMD_KEEP_FIRST, '0, 8'd128);
        send_request(CMD_DROP_FIRST, '0, 8'd128);
        send_request(CMD_DROP_FIRST, '0, 8'd127);
        send_request(CMD_READ_AT,    '0, 8'd0);
        send_request(CMD_POP_FRONT,  '0, 8'd0);
        send_request(CMD_KEEP_FIRST, '0, 8'd0);
        random_requests(170);
        s_tvalid <= 1'b0;

        spins = 0;
        while (sb.pending.size() != 0 && spins < 5000) begin
            @(posedge i_clk);
            spins++;
        end
        repeat (4) @(posedge i_clk);
        if (sb.pending.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, sb.pending.size());
            sb.failures++;
        end

        $display("Sent %0d requests (%0d refused by precondition), list reached %0d of %0d.",
                 sb.requests, sb.refused, sb.peak_fill, DEPTH);
        $display("Input was held back for %0d cycles by result back-pressure.",
                 stalled_cycles);
        if (sb.failures == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/bdq_pkg.sv
src/bounded_array_deque_top.sv
verif/bounded_array_deque_top_test.sv
